>>> design/fdf_pkg.sv
package fdf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_FIRST_HDR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REQUEST_HDR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESPONSE_HDR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EVENT_HDR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd100;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] FRAME_REQUEST  = 2'd0;
  localparam logic [1:0] FRAME_RESPONSE = 2'd1;
  localparam logic [1:0] FRAME_EVENT    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_ERROR = 2'd1;
  localparam logic [1:0] ST_TIMEOUT   = 2'd2;
  localparam logic [1:0] ST_NOTHING   = 2'd3;

  typedef struct packed {
    logic [7:0]  first_hdr;
    logic [7:0]  request_hdr;
    logic [7:0]  response_hdr;
    logic [7:0]  event_hdr;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic        payload_last;
    logic [1:0]  frame_kind;
    logic [31:0] frame_length;
    logic [1:0]  status;
    logic [15:0] received_crc;
  } res_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/fdf_cfg_regs.sv
module fdf_cfg_regs
  import fdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign idx   = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_hdr     <= 8'h00;
      cfg_r.request_hdr   <= 8'h00;
      cfg_r.response_hdr  <= 8'h00;
      cfg_r.event_hdr     <= 8'h00;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_FIRST_HDR:    cfg_r.first_hdr     <= pwdata[7:0];
        REG_REQUEST_HDR:  cfg_r.request_hdr   <= pwdata[7:0];
        REG_RESPONSE_HDR: cfg_r.response_hdr  <= pwdata[7:0];
        REG_EVENT_HDR:    cfg_r.event_hdr     <= pwdata[7:0];
        REG_TIMEOUT:      cfg_r.timeout_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST_HDR:    prdata = {24'h0, cfg_r.first_hdr};
      REG_REQUEST_HDR:  prdata = {24'h0, cfg_r.request_hdr};
      REG_RESPONSE_HDR: prdata = {24'h0, cfg_r.response_hdr};
      REG_EVENT_HDR:    prdata = {24'h0, cfg_r.event_hdr};
      REG_TIMEOUT:      prdata = cfg_r.timeout_ticks;
      default:          prdata = 32'h0;
    endcase
  end

endmodule

>>> design/fdf_parser.sv
module fdf_parser
  import fdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_acc,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_HUNT1   = 3'd0;
  localparam logic [2:0] PH_HUNT2   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [2:0]  phase_r,    phase_nxt;
  logic [1:0]  kind_r,     kind_nxt;
  logic [31:0] len_r,      len_nxt;
  logic [1:0]  len_cnt_r,  len_cnt_nxt;
  logic [31:0] pay_cnt_r,  pay_cnt_nxt;
  logic        crc_cnt_r,  crc_cnt_nxt;
  logic [15:0] crc_rx_r,   crc_rx_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [31:0] idle_r,     idle_nxt;
  logic        seen_r,     seen_nxt;

  logic [15:0] crc_upd;
  logic [31:0] idle_inc;
  logic [31:0] len_shift;
  logic [15:0] crc_rx_shift;
  logic        pay_last;

  assign crc_upd      = crc16_byte((phase_r == PH_HUNT1) ? CRC_INIT : crc_r, rx_byte);
  assign idle_inc     = (idle_r == 32'hFFFF_FFFF) ? idle_r : idle_r + 32'd1;
  assign len_shift    = {len_r[23:0], rx_byte};
  assign crc_rx_shift = {crc_rx_r[7:0], rx_byte};
  assign pay_last     = (pay_cnt_r == len_r - 32'd1);

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    len_nxt     = len_r;
    len_cnt_nxt = len_cnt_r;
    pay_cnt_nxt = pay_cnt_r;
    crc_cnt_nxt = crc_cnt_r;
    crc_rx_nxt  = crc_rx_r;
    crc_nxt     = crc_r;
    idle_nxt    = idle_r;
    seen_nxt    = seen_r;
    res_valid   = 1'b0;
    res         = '0;

    if (item_acc) begin
      if (opcode == OP_TICK) begin
        idle_nxt = idle_inc;
        if (idle_inc >= cfg.timeout_ticks) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_STATUS;
          res.status      = seen_r ? ST_TIMEOUT : ST_NOTHING;
          phase_nxt       = PH_HUNT1;
          len_cnt_nxt     = 2'd0;
          pay_cnt_nxt     = 32'd0;
          crc_cnt_nxt     = 1'b0;
          seen_nxt        = 1'b0;
          idle_nxt        = 32'd0;
        end
      end else begin
        idle_nxt = 32'd0;
        seen_nxt = 1'b1;
        unique case (phase_r)
          PH_HUNT1: begin
            if (rx_byte == cfg.first_hdr) begin
              crc_nxt   = crc_upd;
              phase_nxt = PH_HUNT2;
            end
          end
          PH_HUNT2: begin
            // request wins over response over event on equal registers
            if (rx_byte == cfg.request_hdr || rx_byte == cfg.response_hdr ||
                rx_byte == cfg.event_hdr) begin
              if (rx_byte == cfg.request_hdr) begin
                kind_nxt = FRAME_REQUEST;
              end else if (rx_byte == cfg.response_hdr) begin
                kind_nxt = FRAME_RESPONSE;
              end else begin
                kind_nxt = FRAME_EVENT;
              end
              crc_nxt     = crc_upd;
              len_nxt     = 32'd0;
              len_cnt_nxt = 2'd0;
              phase_nxt   = PH_LEN;
            end else begin
              phase_nxt   = PH_HUNT1;
              len_cnt_nxt = 2'd0;
              pay_cnt_nxt = 32'd0;
              crc_cnt_nxt = 1'b0;
            end
          end
          PH_LEN: begin
            len_nxt     = len_shift;
            crc_nxt     = crc_upd;
            len_cnt_nxt = len_cnt_r + 2'd1;
            if (len_cnt_r == 2'd3) begin
              pay_cnt_nxt = 32'd0;
              crc_cnt_nxt = 1'b0;
              crc_rx_nxt  = 16'h0;
              // empty payload: go straight to the CRC bytes
              phase_nxt   = (len_shift == 32'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            crc_nxt           = crc_upd;
            res_valid         = 1'b1;
            res.result_kind   = KIND_PAYLOAD;
            res.payload_byte  = rx_byte;
            res.payload_index = pay_cnt_r;
            res.payload_last  = pay_last;
            res.frame_kind    = kind_r;
            res.frame_length  = len_r;
            pay_cnt_nxt       = pay_cnt_r + 32'd1;
            if (pay_last) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            crc_rx_nxt = crc_rx_shift;
            if (!crc_cnt_r) begin
              crc_cnt_nxt = 1'b1;
            end else begin
              res_valid        = 1'b1;
              res.result_kind  = KIND_STATUS;
              res.frame_kind   = kind_r;
              res.frame_length = len_r;
              res.status       = (crc_rx_shift == crc_r) ? ST_OK : ST_CRC_ERROR;
              res.received_crc = crc_rx_shift;
              phase_nxt        = PH_HUNT1;
              len_cnt_nxt      = 2'd0;
              pay_cnt_nxt      = 32'd0;
              crc_cnt_nxt      = 1'b0;
              seen_nxt         = 1'b0;
            end
          end
          default: begin
            phase_nxt   = PH_HUNT1;
            len_cnt_nxt = 2'd0;
            pay_cnt_nxt = 32'd0;
            crc_cnt_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT1;
      kind_r    <= 2'd0;
      len_r     <= 32'd0;
      len_cnt_r <= 2'd0;
      pay_cnt_r <= 32'd0;
      crc_cnt_r <= 1'b0;
      crc_rx_r  <= 16'h0;
      crc_r     <= CRC_INIT;
      idle_r    <= 32'd0;
      seen_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      len_r     <= len_nxt;
      len_cnt_r <= len_cnt_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      crc_cnt_r <= crc_cnt_nxt;
      crc_rx_r  <= crc_rx_nxt;
      crc_r     <= crc_nxt;
      idle_r    <= idle_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

>>> design/fdf_out_buf.sv
module fdf_out_buf
  import fdf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r,  out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r,   out_data_nxt;
  res_t skid_data_r,  skid_data_nxt;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      // output stalled: park the new result
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

>>> design/frame_deframer_crc16_core.sv
// Length-prefixed frame parser with CRC-16/CCITT-FALSE. Each input transfer
// carries a received byte (tuser 0) or one timer tick (tuser 1). The parser
// hunts for the first header byte, takes the frame kind from the second,
// reads a 4-byte big-endian length, the payload and a 2-byte big-endian CRC.
// Every payload byte comes out as one result transfer with its index; the
// frame ends with a status transfer (ok or crc error). Enough idle ticks end
// the session with a timeout or nothing-received status. Throughput is one
// input transfer per clock: the byte-wide CRC update and parse step complete
// in the cycle of acceptance, and results go through an output register
// backed by a one-entry skid stage, so in_tready drops only when both hold a
// result.
module frame_deframer_crc16_core
  import fdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // rx_byte
  input  logic                  in_tuser,   // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // payload_byte, payload_index, frame_kind, frame_length, status,
  // received_crc, 4 zero bits
  output logic [95:0]           out_tdata,
  output logic                  out_tuser,  // result_kind
  output logic                  out_tlast,  // payload_last
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;
  logic item_acc;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign cfg_pready = 1'b1;
  assign item_acc   = in_tvalid && in_tready;

  fdf_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  fdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_acc  (item_acc),
    .opcode    (in_tuser),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  fdf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {4'h0, out_res.received_crc, out_res.status, out_res.frame_length,
                      out_res.frame_kind, out_res.payload_index, out_res.payload_byte};
  assign out_tuser = out_res.result_kind;
  assign out_tlast = out_res.payload_last;

endmodule

>>> test/frame_deframer_crc16_core_tb.sv
module frame_deframer_crc16_core_tb
  import fdf_pkg::*;
();

  localparam int CYCLE_LIMIT     = 300000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum logic [2:0] {
    SEEK_SYNC,
    SEEK_KIND,
    READ_LEN,
    READ_BODY,
    READ_CRC
  } parse_phase_t;

  // Shadow copy of the parser: registers, parse state and the results it still owes.
  class deframer_shadow;
    cfg_t         regs;
    parse_phase_t phase_now;
    logic [1:0]   kind;
    logic [31:0]  len;
    logic [1:0]   len_bytes;
    logic [31:0]  body_count;
    logic         crc_half;
    logic [15:0]  crc_rx;
    logic [15:0]  crc_acc;
    logic [31:0]  idle_ticks;
    logic         saw_byte;
    res_t         owed[$];
    int           mismatches;
    int           n_out;
    int           n_payload;
    int           n_status[4];

    function new();
      regs = '0;
      regs.timeout_ticks = TIMEOUT_RESET;
      phase_now = SEEK_SYNC;
      kind = '0;
      len = '0;
      len_bytes = '0;
      body_count = '0;
      crc_half = 1'b0;
      crc_rx = '0;
      crc_acc = CRC_INIT;
      idle_ticks = '0;
      saw_byte = 1'b0;
      mismatches = 0;
      n_out = 0;
      n_payload = 0;
      n_status = '{default: 0};
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_FIRST_HDR:    regs.first_hdr = v[7:0];
        REG_REQUEST_HDR:  regs.request_hdr = v[7:0];
        REG_RESPONSE_HDR: regs.response_hdr = v[7:0];
        REG_EVENT_HDR:    regs.event_hdr = v[7:0];
        REG_TIMEOUT:      regs.timeout_ticks = v;
        default: ;
      endcase
    endfunction

    // bit-serial CRC-16, MSB first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ d[k];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void restart();
      phase_now = SEEK_SYNC;
      len_bytes = '0;
      body_count = '0;
      crc_half = 1'b0;
    endfunction

    function void take_input(logic op, logic [7:0] b);
      res_t r;
      r = '0;
      if (op == OP_TICK) begin
        if (idle_ticks != 32'hFFFF_FFFF) idle_ticks++;
        if (idle_ticks >= regs.timeout_ticks) begin
          r.result_kind = KIND_STATUS;
          r.status = saw_byte ? ST_TIMEOUT : ST_NOTHING;
          owed.push_back(r);
          restart();
          saw_byte = 1'b0;
          idle_ticks = '0;
        end
        return;
      end
      idle_ticks = '0;
      saw_byte = 1'b1;
      case (phase_now)
        SEEK_SYNC: begin
          if (b == regs.first_hdr) begin
            crc_acc = crc_step(CRC_INIT, b);
            phase_now = SEEK_KIND;
          end
        end
        SEEK_KIND: begin
          // request wins over response over event when the bytes are equal
          if (b == regs.request_hdr) kind = FRAME_REQUEST;
          else if (b == regs.response_hdr) kind = FRAME_RESPONSE;
          else if (b == regs.event_hdr) kind = FRAME_EVENT;
          else begin
            restart();
            return;
          end
          crc_acc = crc_step(crc_acc, b);
          len = '0;
          len_bytes = '0;
          phase_now = READ_LEN;
        end
        READ_LEN: begin
          len = {len[23:0], b};
          crc_acc = crc_step(crc_acc, b);
          len_bytes = len_bytes + 2'd1;
          if (len_bytes == 2'd0) begin
            body_count = '0;
            crc_half = 1'b0;
            crc_rx = '0;
            phase_now = (len == 32'd0) ? READ_CRC : READ_BODY;
          end
        end
        READ_BODY: begin
          r.result_kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = body_count;
          r.payload_last = (body_count == len - 32'd1);
          r.frame_kind = kind;
          r.frame_length = len;
          crc_acc = crc_step(crc_acc, b);
          body_count++;
          if (r.payload_last) phase_now = READ_CRC;
          owed.push_back(r);
        end
        READ_CRC: begin
          crc_rx = {crc_rx[7:0], b};
          if (!crc_half) begin
            crc_half = 1'b1;
          end else begin
            r.result_kind = KIND_STATUS;
            r.frame_kind = kind;
            r.frame_length = len;
            r.status = (crc_rx == crc_acc) ? ST_OK : ST_CRC_ERROR;
            r.received_crc = crc_rx;
            owed.push_back(r);
            restart();
            saw_byte = 1'b0;
          end
        end
        default: restart();
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at result %0d: %s", n_out, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task match_output(res_t got, logic [3:0] pad);
      res_t want;
      n_out++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected transfer, kind %0d", got.result_kind));
        return;
      end
      want = owed.pop_front();
      check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
      check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
      check_field("payload_index", got.payload_index, want.payload_index);
      check_field("payload_last", 32'(got.payload_last), 32'(want.payload_last));
      check_field("frame_kind", 32'(got.frame_kind), 32'(want.frame_kind));
      check_field("frame_length", got.frame_length, want.frame_length);
      check_field("status", 32'(got.status), 32'(want.status));
      check_field("received_crc", 32'(got.received_crc), 32'(want.received_crc));
      check_field("pad bits", 32'(pad), 32'd0);
      if (want.result_kind == KIND_PAYLOAD) n_payload++;
      else n_status[want.status]++;
    endtask

    task flag_leftovers();
      while (owed.size() != 0) begin
        report($sformatf("result never arrived, kind %0d", owed[0].result_kind));
        void'(owed.pop_front());
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;     // rx_byte
  logic                  in_tuser = 1'b0;   // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // payload_byte, payload_index, frame_kind, frame_length, status, received_crc, pad
  logic [95:0]           out_tdata;
  logic                  out_tuser;         // result_kind
  logic                  out_tlast;         // payload_last
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  deframer_shadow shadow;
  int   cycle_count = 0;
  int   inputs_sent = 0;
  logic steady = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;
  int   hold_off_count = 0;

  frame_deframer_crc16_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results pending", shadow.owed.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: one long hold-off on request, otherwise random or steady ready.
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      out_tready <= 1'b0;
      hold_off_count <= hold_off_count + 1;
      if (hold_off_count == HOLD_OFF_CYCLES - 1) hold_off_done <= 1'b1;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 33);
    end
  end

  function automatic res_t unpack_result(logic [95:0] d, logic kind, logic last);
    res_t r;
    r.result_kind = kind;
    r.payload_byte = d[7:0];
    r.payload_index = d[39:8];
    r.payload_last = last;
    r.frame_kind = d[41:40];
    r.frame_length = d[73:42];
    r.status = d[75:74];
    r.received_crc = d[91:76];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      shadow.match_output(unpack_result(out_tdata, out_tuser, out_tlast), out_tdata[95:92]);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.take_input(op, b);
    inputs_sent++;
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    shadow.set_reg(idx, v);
  endtask

  task automatic configure(input logic [7:0] first, input logic [7:0] req,
                           input logic [7:0] resp, input logic [7:0] evt,
                           input logic [31:0] ticks);
    cfg_write(REG_FIRST_HDR, {24'd0, first});
    cfg_write(REG_REQUEST_HDR, {24'd0, req});
    cfg_write(REG_RESPONSE_HDR, {24'd0, resp});
    cfg_write(REG_EVENT_HDR, {24'd0, evt});
    cfg_write(REG_TIMEOUT, ticks);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Let every owed result drain, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(input int kind_sel, input int len, input bit corrupt,
                            input int gap_ticks_max);
    logic [7:0]  bytes_out[$];
    logic [15:0] crc;
    logic [7:0]  second;
    case (kind_sel)
      0:       second = shadow.regs.request_hdr;
      1:       second = shadow.regs.response_hdr;
      default: second = shadow.regs.event_hdr;
    endcase
    bytes_out.push_back(shadow.regs.first_hdr);
    bytes_out.push_back(second);
    bytes_out.push_back(len[31:24]);
    bytes_out.push_back(len[23:16]);
    bytes_out.push_back(len[15:8]);
    bytes_out.push_back(len[7:0]);
    for (int i = 0; i < len; i++) bytes_out.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (bytes_out[i]) crc = shadow.crc_step(crc, bytes_out[i]);
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
    bytes_out.push_back(crc[15:8]);
    bytes_out.push_back(crc[7:0]);
    foreach (bytes_out[i]) begin
      // idle ticks inside a frame stay short of the timeout
      if (gap_ticks_max > 0 && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, gap_ticks_max)) send_item(OP_TICK, 8'($urandom));
      end
      send_item(OP_BYTE, bytes_out[i]);
    end
  endtask

  // Bad kind byte, or a truncated frame recovered by running out the timeout.
  task automatic send_broken();
    logic [7:0]  b;
    logic [31:0] len;
    if ($urandom_range(0, 1) == 1) begin
      send_item(OP_BYTE, shadow.regs.first_hdr);
      b = 8'($urandom);
      while (b == shadow.regs.request_hdr || b == shadow.regs.response_hdr ||
             b == shadow.regs.event_hdr) b = b + 8'd1;
      send_item(OP_BYTE, b);
    end else begin
      len = $urandom;
      send_item(OP_BYTE, shadow.regs.first_hdr);
      send_item(OP_BYTE, shadow.regs.event_hdr);
      send_item(OP_BYTE, len[31:24]);
      send_item(OP_BYTE, len[23:16]);
      send_item(OP_BYTE, len[15:8]);
      send_item(OP_BYTE, len[7:0]);
      repeat ($urandom_range(0, 3)) send_item(OP_BYTE, 8'($urandom));
      repeat ((shadow.regs.timeout_ticks == 0) ? 1 : shadow.regs.timeout_ticks) begin
        send_item(OP_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic run_random(input int quota, input int gap_ticks_max, input bit broken_ok);
    int         target;
    int         pick;
    logic [7:0] b;
    target = inputs_sent + quota;
    while (inputs_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame($urandom_range(0, 2),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12),
                   $urandom_range(0, 3) == 0, gap_ticks_max);
      end else if (pick < 80) begin
        // noise never starts a frame, so a long timeout cannot strand the parser
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom);
          if (b == shadow.regs.first_hdr) b = ~b;
          send_item(OP_BYTE, b);
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom));
      end else if (broken_ok) begin
        send_broken();
      end
    end
  endtask

  initial begin
    int tmo;
    shadow = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle session, hunting noise, unrechecked kind byte, equal kind
    // bytes with zero length, crc error, timeout in the middle of a frame
    configure(8'hA5, 8'h5A, 8'h5A, 8'hFF, 32'd3);
    repeat (3) send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_BYTE, 8'hA5);
    send_frame(1, 0, 1'b0, 0);
    send_frame(2, 2, 1'b1, 0);
    send_item(OP_BYTE, 8'hA5);
    repeat (3) send_item(OP_TICK, 8'hFF);
    drain();

    // zero timeout: every tick ends the session
    configure(8'h00, 8'hFF, 8'h80, 8'h7E, 32'd0);
    run_random(450, 0, 1'b1);
    drain();

    // timeout never reached; first part with both sides always ready
    configure(8'hFF, 8'h00, 8'h01, 8'h01, 32'hFFFF_FFFF);
    steady <= 1'b1;
    run_random(300, 50, 1'b0);
    steady <= 1'b0;
    run_random(350, 50, 1'b0);
    drain();

    // random headers, short timeout; receiver holds off while a frame streams in
    tmo = $urandom_range(2, 8);
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), tmo);
    hold_off_req <= 1'b1;
    send_frame(0, 30, 1'b0, 0);
    run_random(750, tmo - 1, 1'b1);
    drain();

    repeat (10) @(posedge clk);
    shadow.flag_leftovers();
    $display("Sent %0d input transfers under four register settings, incl. zero and max timeout",
             inputs_sent);
    $display("Checked %0d payload and %0d status results (ok %0d, crc %0d, timeout %0d, idle %0d)",
             shadow.n_payload,
             shadow.n_status[0] + shadow.n_status[1] + shadow.n_status[2] + shadow.n_status[3],
             shadow.n_status[ST_OK], shadow.n_status[ST_CRC_ERROR],
             shadow.n_status[ST_TIMEOUT], shadow.n_status[ST_NOTHING]);
    if (shadow.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
